// ===== rtl/rfft_pkg.sv =====
// Shared types, constants and twiddle functions for the real-input FFT core.
// Used by rfft_ctrl, rfft_datapath and real_fft_radix2_core; depends on nothing.
package rfft_pkg;

   localparam int DEF_REAL_POINTS = 128;
   localparam int DEF_SAMPLE_BITS = 16;
   localparam int SAMPLE_W        = 16;
   localparam int BIN_W           = 6;
   localparam int OUT_W           = 25;
   localparam int TWID_W          = 18;
   localparam int ADDR_MAX_W      = 6;
   localparam int TWID_IDX_W      = 7;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_BF_RA,
      ST_BF_RB,
      ST_BF_LB,
      ST_BF_MUL,
      ST_BF_SUM,
      ST_BF_WA,
      ST_BF_WB,
      ST_SP_RA,
      ST_SP_RB,
      ST_SP_LB,
      ST_SP_MR,
      ST_SP_MI,
      ST_SP_SI,
      ST_SP_OUT
   } state_type;

   typedef enum logic [1:0] {
      MUL_BF,
      MUL_SR,
      MUL_SI
   } mul_mode_type;

   typedef enum logic [1:0] {
      SUM_NONE,
      SUM_BF,
      SUM_SR,
      SUM_SI
   } sum_mode_type;

   typedef struct packed {
      logic [ADDR_MAX_W-1:0] addr_a;
      logic [ADDR_MAX_W-1:0] addr_b;
      logic                  rd_b;
      logic                  lat_a;
      logic                  lat_b;
      logic                  smp_even;
      logic                  wr_smp;
      logic                  wr_sum;
      logic                  wr_dif;
      mul_mode_type          mul_mode;
      sum_mode_type          sum_mode;
      logic [TWID_IDX_W-1:0] twid;
      logic                  out_load;
      logic [BIN_W-1:0]      bin;
      logic                  bin_zero;
      logic                  bin_last;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

   // First quarter of the cosine wave in Q3.15 (18-bit signed), index 0..32.
   function automatic logic signed [TWID_W-1:0] cos_quarter(input logic [5:0] r);
      logic signed [TWID_W-1:0] v;
      case (r)
         6'd0:  v = 18'sd32768;
         6'd1:  v = 18'sd32729;
         6'd2:  v = 18'sd32610;
         6'd3:  v = 18'sd32413;
         6'd4:  v = 18'sd32138;
         6'd5:  v = 18'sd31786;
         6'd6:  v = 18'sd31357;
         6'd7:  v = 18'sd30853;
         6'd8:  v = 18'sd30274;
         6'd9:  v = 18'sd29622;
         6'd10: v = 18'sd28899;
         6'd11: v = 18'sd28106;
         6'd12: v = 18'sd27246;
         6'd13: v = 18'sd26320;
         6'd14: v = 18'sd25330;
         6'd15: v = 18'sd24279;
         6'd16: v = 18'sd23170;
         6'd17: v = 18'sd22006;
         6'd18: v = 18'sd20788;
         6'd19: v = 18'sd19520;
         6'd20: v = 18'sd18205;
         6'd21: v = 18'sd16846;
         6'd22: v = 18'sd15447;
         6'd23: v = 18'sd14010;
         6'd24: v = 18'sd12540;
         6'd25: v = 18'sd11039;
         6'd26: v = 18'sd9512;
         6'd27: v = 18'sd7962;
         6'd28: v = 18'sd6393;
         6'd29: v = 18'sd4808;
         6'd30: v = 18'sd3212;
         6'd31: v = 18'sd1608;
         default: v = 18'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [TWID_W-1:0] cos_tab(input logic [TWID_IDX_W-1:0] m);
      logic [5:0] r;
      logic [5:0] rc;
      logic signed [TWID_W-1:0] v;
      r  = {1'b0, m[4:0]};
      rc = 6'd32 - r;
      case (m[6:5])
         2'd0:    v = cos_quarter(r);
         2'd1:    v = -cos_quarter(rc);
         2'd2:    v = -cos_quarter(r);
         default: v = cos_quarter(rc);
      endcase
      return v;
   endfunction

   function automatic logic signed [TWID_W-1:0] sin_tab(input logic [TWID_IDX_W-1:0] m);
      return cos_tab(m + 7'd96);
   endfunction

endpackage

// ===== rtl/rfft_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the pair store of the FFT core.
module rfft_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rfft_ctrl.sv =====
// Controller of the FFT core: loading, butterfly sequencing and split sequencing.
// Depends on rfft_pkg; drives rfft_datapath through cmd_type.
module rfft_ctrl #(
   parameter int REAL_POINTS = rfft_pkg::DEF_REAL_POINTS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rfft_pkg::status_type st,
   output rfft_pkg::cmd_type    cmd
);
   import rfft_pkg::*;

   localparam int HALF     = REAL_POINTS / 2;
   localparam int LOG      = $clog2(HALF);
   localparam int STW      = (LOG > 1) ? $clog2(LOG) : 1;
   localparam int TW_SHIFT = 6 - LOG;
   localparam logic [LOG-1:0] BF_LAST  = LOG'(HALF / 2 - 1);
   localparam logic [LOG-1:0] BIN_LAST = LOG'(HALF - 1);
   localparam logic [STW-1:0] ST_LAST  = STW'(LOG - 1);
   localparam logic [LOG:0]   LD_LAST  = (LOG + 1)'(REAL_POINTS - 1);

   state_type      state_ff, state_in;
   logic [LOG:0]   load_ff, load_in;
   logic [STW-1:0] stage_ff, stage_in;
   logic [LOG-1:0] idx_ff, idx_in;
   logic           take;

   assign take = req_valid && (state_ff == ST_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         load_ff  <= '0;
         stage_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         load_ff  <= load_in;
         stage_ff <= stage_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      load_in  = load_ff;
      stage_in = stage_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_LOAD: begin
            if (take) begin
               load_in = load_ff + 1'b1;
               if (load_ff == LD_LAST) begin
                  load_in  = '0;
                  stage_in = '0;
                  idx_in   = '0;
                  state_in = ST_BF_RA;
               end
            end
         end
         ST_BF_RA:  state_in = ST_BF_RB;
         ST_BF_RB:  state_in = ST_BF_LB;
         ST_BF_LB:  state_in = ST_BF_MUL;
         ST_BF_MUL: state_in = ST_BF_SUM;
         ST_BF_SUM: state_in = ST_BF_WA;
         ST_BF_WA:  state_in = ST_BF_WB;
         ST_BF_WB: begin
            state_in = ST_BF_RA;
            idx_in   = idx_ff + 1'b1;
            if (idx_ff == BF_LAST) begin
               idx_in = '0;
               if (stage_ff == ST_LAST) begin
                  state_in = ST_SP_RA;
               end else begin
                  stage_in = stage_ff + 1'b1;
               end
            end
         end
         ST_SP_RA: state_in = ST_SP_RB;
         ST_SP_RB: state_in = ST_SP_LB;
         ST_SP_LB: state_in = ST_SP_MR;
         ST_SP_MR: state_in = ST_SP_MI;
         ST_SP_MI: state_in = ST_SP_SI;
         ST_SP_SI: state_in = ST_SP_OUT;
         ST_SP_OUT: begin
            if (!st.out_busy) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SP_RA;
               if (idx_ff == BIN_LAST) begin
                  idx_in   = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      logic [LOG-1:0] slot;
      logic [LOG-1:0] rev;
      logic [LOG-1:0] mask;
      logic [LOG-1:0] pos;
      logic [LOG-1:0] ja;
      logic [LOG-1:0] jb;
      logic [11:0]    mwide;
      slot = load_ff[LOG:1];
      for (int b = 0; b < LOG; b++) begin
         rev[LOG-1-b] = slot[b];
      end
      mask  = (LOG'(1) << stage_ff) - 1'b1;
      pos   = idx_ff & mask;
      ja    = ((idx_ff >> stage_ff) << (stage_ff + 1'b1)) | pos;
      jb    = ja | (LOG'(1) << stage_ff);
      mwide = (12'(pos) << 6) >> stage_ff;

      req_ready    = (state_ff == ST_LOAD);
      cmd          = '0;
      cmd.mul_mode = MUL_BF;
      cmd.sum_mode = SUM_NONE;
      cmd.bin      = BIN_W'(idx_ff);
      cmd.bin_zero = (idx_ff == '0);
      cmd.bin_last = (idx_ff == BIN_LAST);
      case (state_ff)
         ST_LOAD, ST_BF_RA, ST_BF_RB, ST_BF_LB, ST_BF_MUL, ST_BF_SUM, ST_BF_WA,
         ST_BF_WB: begin
            cmd.addr_a = ADDR_MAX_W'(ja);
            cmd.addr_b = ADDR_MAX_W'(jb);
            cmd.twid   = mwide[TWID_IDX_W-1:0];
         end
         default: begin
            cmd.addr_a = ADDR_MAX_W'(idx_ff);
            cmd.addr_b = ADDR_MAX_W'(LOG'(0) - idx_ff);
            cmd.twid   = TWID_IDX_W'(idx_ff) << TW_SHIFT;
         end
      endcase
      case (state_ff)
         ST_LOAD: begin
            cmd.addr_a   = ADDR_MAX_W'(rev);
            cmd.smp_even = take && !load_ff[0];
            cmd.wr_smp   = take && load_ff[0];
         end
         ST_BF_RB, ST_SP_RB: begin
            cmd.rd_b  = 1'b1;
            cmd.lat_a = 1'b1;
         end
         ST_BF_LB, ST_SP_LB: cmd.lat_b = 1'b1;
         ST_BF_MUL: cmd.mul_mode = MUL_BF;
         ST_BF_SUM: cmd.sum_mode = SUM_BF;
         ST_BF_WA:  cmd.wr_sum   = 1'b1;
         ST_BF_WB:  cmd.wr_dif   = 1'b1;
         ST_SP_MR:  cmd.mul_mode = MUL_SR;
         ST_SP_MI: begin
            cmd.mul_mode = MUL_SI;
            cmd.sum_mode = SUM_SR;
         end
         ST_SP_SI:  cmd.sum_mode = SUM_SI;
         ST_SP_OUT: cmd.out_load = !st.out_busy;
         default: cmd.rd_b = 1'b0;
      endcase
   end

endmodule

// ===== rtl/rfft_datapath.sv =====
// Datapath of the FFT core: pair store, multiplier bank, adders and result register.
// Depends on rfft_pkg and rfft_ram; commanded by rfft_ctrl.
module rfft_datapath #(
   parameter int REAL_POINTS = rfft_pkg::DEF_REAL_POINTS,
   parameter int SAMPLE_BITS = rfft_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rfft_pkg::cmd_type                      cmd,
   output rfft_pkg::status_type                   st,
   input  logic signed [rfft_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [rfft_pkg::BIN_W-1:0]             rsp_bin_index,
   output logic signed [rfft_pkg::OUT_W-1:0]      rsp_real_part,
   output logic signed [rfft_pkg::OUT_W-1:0]      rsp_imag_part,
   output logic                                   rsp_last_bin
);
   import rfft_pkg::*;

   localparam int HALF = REAL_POINTS / 2;
   localparam int AW   = $clog2(HALF);
   localparam int DW   = SAMPLE_BITS + 9;
   localparam int PW   = DW + TWID_W;
   localparam int SW   = PW + 2;
   localparam int EXTW = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

   logic [EXTW-1:0]          smp_ext;
   logic signed [SAMPLE_BITS-1:0] smp_low;
   logic signed [DW-1:0]     smp_val;
   logic signed [DW-1:0]     even_ff;
   logic signed [DW-1:0]     a_re_ff, a_im_ff, b_re_ff, b_im_ff;
   logic signed [DW-1:0]     d_re_ff, d_im_ff;
   logic signed [SW-1:0]     s_re_ff, s_im_ff;
   logic signed [TWID_W-1:0] tc_ff, ts_ff, ta_ff, tb_ff;
   logic signed [PW-1:0]     p_ff [4];
   logic signed [PW-1:0]     p_in [4];
   logic signed [DW-1:0]     opx [4];
   logic signed [TWID_W-1:0] opt [4];
   logic                     wr_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic [2*DW-1:0]          wr_data, rd_data;
   logic signed [DW-1:0]     rd_re, rd_im;
   logic signed [SW-1:0]     sum_bf_re, sum_bf_im, sum_sr, sum_si;
   logic signed [SW-1:0]     rnd_re, rnd_im;
   logic signed [DW:0]       nyq;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]         bin_ff;
   logic signed [OUT_W-1:0]  re_ff, im_ff;
   logic                     last_ff;

   assign smp_ext = EXTW'(unsigned'(req_sample));
   assign smp_low = signed'(smp_ext[SAMPLE_BITS-1:0]);
   assign smp_val = DW'(smp_low);

   assign rd_re = signed'(rd_data[2*DW-1:DW]);
   assign rd_im = signed'(rd_data[DW-1:0]);

   always_comb begin
      wr_en   = cmd.wr_smp || cmd.wr_sum || cmd.wr_dif;
      wr_addr = cmd.wr_dif ? cmd.addr_b[AW-1:0] : cmd.addr_a[AW-1:0];
      rd_addr = cmd.rd_b ? cmd.addr_b[AW-1:0] : cmd.addr_a[AW-1:0];
      if (cmd.wr_smp) begin
         wr_data = {even_ff, smp_val};
      end else if (cmd.wr_sum) begin
         wr_data = {a_re_ff + d_re_ff, a_im_ff + d_im_ff};
      end else begin
         wr_data = {a_re_ff - d_re_ff, a_im_ff - d_im_ff};
      end
   end

   rfft_ram #(
      .WIDTH(2 * DW),
      .DEPTH(HALF)
   ) u_pair_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Operand selection for the four multipliers.
   always_comb begin
      case (cmd.mul_mode)
         MUL_SR: begin
            opx[0] = a_re_ff; opt[0] = ta_ff;
            opx[1] = a_im_ff; opt[1] = tc_ff;
            opx[2] = b_re_ff; opt[2] = tb_ff;
            opx[3] = b_im_ff; opt[3] = tc_ff;
         end
         MUL_SI: begin
            opx[0] = a_im_ff; opt[0] = ta_ff;
            opx[1] = a_re_ff; opt[1] = tc_ff;
            opx[2] = b_re_ff; opt[2] = tc_ff;
            opx[3] = b_im_ff; opt[3] = tb_ff;
         end
         default: begin
            opx[0] = b_re_ff; opt[0] = tc_ff;
            opx[1] = b_im_ff; opt[1] = ts_ff;
            opx[2] = b_im_ff; opt[2] = tc_ff;
            opx[3] = b_re_ff; opt[3] = ts_ff;
         end
      endcase
      for (int i = 0; i < 4; i++) begin
         p_in[i] = PW'(opx[i]) * PW'(opt[i]);
      end
   end

   always_comb begin
      sum_bf_re = SW'(p_ff[0]) + SW'(p_ff[1]) + SW'(32'sd16384);
      sum_bf_im = SW'(p_ff[2]) - SW'(p_ff[3]) + SW'(32'sd16384);
      sum_sr    = SW'(p_ff[0]) + SW'(p_ff[1]) + SW'(p_ff[2]) + SW'(p_ff[3]);
      sum_si    = SW'(p_ff[0]) - SW'(p_ff[1]) + SW'(p_ff[2]) - SW'(p_ff[3]);
      rnd_re    = (s_re_ff + SW'(32'sd32768)) >>> 16;
      rnd_im    = (s_im_ff + SW'(32'sd32768)) >>> 16;
      nyq       = (DW + 1)'(a_re_ff) - (DW + 1)'(a_im_ff);
   end

   always_ff @(posedge clock) begin
      tc_ff <= cos_tab(cmd.twid);
      ts_ff <= sin_tab(cmd.twid);
      ta_ff <= TWID_W'(32'sd32768) - sin_tab(cmd.twid);
      tb_ff <= TWID_W'(32'sd32768) + sin_tab(cmd.twid);
      for (int i = 0; i < 4; i++) begin
         p_ff[i] <= p_in[i];
      end
      if (cmd.smp_even) begin
         even_ff <= smp_val;
      end
      if (cmd.lat_a) begin
         a_re_ff <= rd_re;
         a_im_ff <= rd_im;
      end
      if (cmd.lat_b) begin
         b_re_ff <= rd_re;
         b_im_ff <= rd_im;
      end
      if (cmd.sum_mode == SUM_BF) begin
         d_re_ff <= DW'(sum_bf_re >>> 15);
         d_im_ff <= DW'(sum_bf_im >>> 15);
      end
      if (cmd.sum_mode == SUM_SR) begin
         s_re_ff <= sum_sr;
      end
      if (cmd.sum_mode == SUM_SI) begin
         s_im_ff <= sum_si;
      end
      if (cmd.out_load) begin
         bin_ff  <= cmd.bin;
         last_ff <= cmd.bin_last;
         re_ff   <= OUT_W'(rnd_re);
         // Bin 0 carries the Nyquist term in its imaginary slot.
         im_ff   <= cmd.bin_zero ? OUT_W'(nyq) : OUT_W'(rnd_im);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign st.out_busy   = rsp_valid_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_index = bin_ff;
   assign rsp_real_part = re_ff;
   assign rsp_imag_part = im_ff;
   assign rsp_last_bin  = last_ff;

endmodule

// ===== rtl/real_fft_radix2_core.sv =====
// Real-input FFT core. Samples are taken one per cycle while the core is loading; each
// butterfly of the half-length complex FFT steps through the pair store: read A, read B,
// latch B, multiply, sum, write A, write B. Each output bin is read, latched, multiplied
// and summed, then waits until the output register is free before it is loaded.
// Results are held in an output register; the next bin is computed while one waits.
// Synchronous active-high reset returns the core to loading with an empty frame.
module real_fft_radix2_core #(
   parameter int REAL_POINTS = rfft_pkg::DEF_REAL_POINTS,
   parameter int SAMPLE_BITS = rfft_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [rfft_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [rfft_pkg::BIN_W-1:0]           rsp_bin_index,
   output logic signed [rfft_pkg::OUT_W-1:0]    rsp_real_part,
   output logic signed [rfft_pkg::OUT_W-1:0]    rsp_imag_part,
   output logic                                 rsp_last_bin
);
   import rfft_pkg::*;

   cmd_type    cmd;
   status_type st;

   rfft_ctrl #(
      .REAL_POINTS(REAL_POINTS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .st       (st),
      .cmd      (cmd)
   );

   rfft_datapath #(
      .REAL_POINTS(REAL_POINTS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .st           (st),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_bin_index(rsp_bin_index),
      .rsp_real_part(rsp_real_part),
      .rsp_imag_part(rsp_imag_part),
      .rsp_last_bin (rsp_last_bin)
   );

   // The store is never written by the transform while samples are being taken.
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(cmd.wr_sum || cmd.wr_dif))
      else $error("transform write while loading");

   // The final result of a frame always carries the top bin number.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_bin) |-> (rsp_bin_index == BIN_W'(REAL_POINTS / 2 - 1)))
      else $error("last_bin on wrong bin");

   // A new result is only loaded once the previous one has been taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_real_part) && $stable(rsp_bin_index))
      else $error("result overwritten while stalled");

endmodule
